// ===== rtl/sorted_priority_queue_multikey_top_defines.svh =====
// assertion macros for the sorted priority queue
// included by modules that carry concurrent assertions; no other dependencies
`ifndef SORTED_PRIORITY_QUEUE_MULTIKEY_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_MULTIKEY_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SPQM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SPQM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spqm_pkg.sv =====
// types, codes and key packing for the sorted priority queue
// no dependencies
`timescale 1ns / 1ps

package spqm_pkg;

    localparam int KEY_W   = 46;
    localparam int TAG_W   = 16;
    localparam int OCC_W   = 5;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t            opcode;
        logic signed [7:0]  priority_level;
        logic [11:0]        year_value;
        logic [3:0]         month_value;
        logic [4:0]         day_value;
        logic [4:0]         hour_value;
        logic [5:0]         minute_value;
        logic [5:0]         second_value;
        logic [TAG_W-1:0]   payload_tag;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic signed [7:0]  out_priority;
        logic [11:0]        out_year;
        logic [3:0]         out_month;
        logic [4:0]         out_day;
        logic [4:0]         out_hour;
        logic [5:0]         out_minute;
        logic [5:0]         out_second;
        logic [TAG_W-1:0]   out_tag;
        logic [OCC_W-1:0]   occupancy;
    } out_item_t;

    // one stored entry: ordering key and tag
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    // command broadcast to every cell
    typedef struct packed {
        logic               insert;
        logic               remove;
        entry_t             entry;
    } cell_cmd_t;

    // importance gets its sign bit flipped so an unsigned compare orders it
    function automatic entry_t make_entry(input in_item_t item);
        entry_t e;
        e.key = {item.priority_level ^ 8'h80, item.year_value, item.month_value,
                 item.day_value, item.hour_value, item.minute_value,
                 item.second_value};
        e.tag = item.payload_tag;
        return e;
    endfunction

endpackage

// ===== rtl/spqm_cell.sv =====
// one cell of the sorted chain: holds one entry, compares it with the new key
// depends on spqm_pkg
`timescale 1ns / 1ps

module spqm_cell (
    input  logic               aclk,
    input  spqm_pkg::cell_cmd_t cmd,
    input  logic               occupied,
    input  logic               left_ge,
    input  spqm_pkg::entry_t   left_entry,
    input  spqm_pkg::entry_t   right_entry,
    output logic               ge,
    output spqm_pkg::entry_t   entry
);

    spqm_pkg::entry_t entry_reg;
    spqm_pkg::entry_t entry_next;

    // stays ahead of the new item when its key is greater or equal
    assign ge    = occupied && (entry_reg.key >= cmd.entry.key);
    assign entry = entry_reg;

    // insert: keep, take the new entry, or take the left neighbor's
    // remove: take the right neighbor's
    always_comb begin
        entry_next = entry_reg;
        if (cmd.insert) begin
            if (!ge) begin
                entry_next = left_ge ? cmd.entry : left_entry;
            end
        end else if (cmd.remove) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/sorted_priority_queue_multikey_top.sv =====
// Sorted priority queue, top level.
// Input channel s_*: one item per handshake, opcode insert or remove with the
// entry's importance, date, time and tag. Result channel m_*: exactly one item
// per input item, with status (ok, full on insert, empty on remove), the
// removed entry's fields (zero otherwise) and the occupancy afterwards.
// Entries sit in a row of QUEUE_DEPTH cells ordered from highest key to
// lowest; every cell compares its key with the new one in parallel and shifts
// toward its neighbor in the same cycle, so equal keys leave in arrival order.
// The result is registered and shows in the cycle after acceptance.
// Throughput: one item per cycle; the single output register is the only
// buffer, so s_ready follows m_ready whenever a result is waiting.
// While the receiver stalls, the result holds and no new item is taken.
// Reset (aresetn low, synchronous) empties the queue, holds s_ready low and
// drops any pending result; no clearing pass is needed, the cells are read
// only below the count.
// depends on spqm_pkg, spqm_cell and sorted_priority_queue_multikey_top_defines.svh
`timescale 1ns / 1ps
`include "sorted_priority_queue_multikey_top_defines.svh"

module sorted_priority_queue_multikey_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  spqm_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output spqm_pkg::out_item_t   m_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]        count_reg, count_next;
    logic                 m_valid_reg, m_valid_next;
    spqm_pkg::out_item_t  out_reg, out_next;

    spqm_pkg::cell_cmd_t  cmd;
    spqm_pkg::entry_t     cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_ge;
    logic [QUEUE_DEPTH-1:0] occupied;

    logic                 accept;
    logic                 is_insert;
    logic                 full;
    logic                 empty;
    logic [CW+4:0]        count_wide;
    spqm_pkg::entry_t     head;

    // handshake
    assign s_ready   = aresetn && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign is_insert = (s_data.opcode == spqm_pkg::OP_INSERT);
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);

    // command to the cell row
    always_comb begin
        cmd.insert = accept && is_insert && !full;
        cmd.remove = accept && !is_insert && !empty;
        cmd.entry  = spqm_pkg::make_entry(s_data);
    end

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic             left_ge;
            spqm_pkg::entry_t left_entry;
            spqm_pkg::entry_t right_entry;

            assign occupied[gi] = (CW'(gi) < count_reg);

            if (gi == 0) begin : g_first
                assign left_ge    = 1'b1;
                assign left_entry = cmd.entry;
            end else begin : g_mid
                assign left_ge    = cell_ge[gi-1];
                assign left_entry = cell_entry[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign right_entry = cell_entry[gi];
            end else begin : g_inner
                assign right_entry = cell_entry[gi+1];
            end

            spqm_cell u_cell (
                .aclk        (aclk),
                .cmd         (cmd),
                .occupied    (occupied[gi]),
                .left_ge     (left_ge),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .ge          (cell_ge[gi]),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    assign head = cell_entry[0];

    // count update
    always_comb begin
        count_next = count_reg;
        if (cmd.insert) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.remove) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign count_wide = {5'd0, count_next};

    // result item
    always_comb begin
        out_next           = out_reg;
        m_valid_next       = m_valid_reg;
        if (accept) begin
            m_valid_next       = 1'b1;
            out_next           = '0;
            out_next.status    = spqm_pkg::ST_OK;
            out_next.occupancy = count_wide[4:0];
            if (is_insert) begin
                if (full) begin
                    out_next.status = spqm_pkg::ST_FULL;
                end
            end else if (empty) begin
                out_next.status = spqm_pkg::ST_EMPTY;
            end else begin
                out_next.out_priority = head.key[45:38] ^ 8'h80;
                out_next.out_year     = head.key[37:26];
                out_next.out_month    = head.key[25:22];
                out_next.out_day      = head.key[21:17];
                out_next.out_hour     = head.key[16:12];
                out_next.out_minute   = head.key[11:6];
                out_next.out_second   = head.key[5:0];
                out_next.out_tag      = head.tag;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // checks
    `SPQM_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= CW'(QUEUE_DEPTH), "entry count above depth")
    `SPQM_ASSERT_NEXT(a_insert_grows, aclk, aresetn, cmd.insert,
        count_reg == $past(count_reg) + 1'b1, "insert did not grow the count")
    `SPQM_ASSERT_NEXT(a_remove_head, aclk, aresetn, cmd.remove,
        m_valid && m_data.out_tag == $past(head.tag), "removed tag is not the head")
    `SPQM_ASSERT_NEXT(a_empty_status, aclk, aresetn, accept && !is_insert && empty,
        m_valid && m_data.status == spqm_pkg::ST_EMPTY && count_reg == '0,
        "remove on empty queue misreported")
    `SPQM_ASSERT_NEXT(a_full_holds, aclk, aresetn, accept && is_insert && full,
        m_data.status == spqm_pkg::ST_FULL && count_reg == CW'(QUEUE_DEPTH),
        "insert on full queue misreported")

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for sorted_priority_queue_multikey_top
// depends on spqm_pkg and the queue top level; a class predicts and checks every result
`timescale 1ns / 1ps

module tb;
    import spqm_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int CYCLE_LIMIT = 400000;

    // one stored entry as the predictor keeps it
    typedef struct packed {
        logic [45:0] rank;
        logic [15:0] tag;
    } queue_slot_t;

    // predicts the queue contents and checks each result in order
    class priority_order_checker;
        queue_slot_t slots [QDEPTH];
        int          fill;
        out_item_t   pending_results [$];
        int          mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        // importance gets its sign flipped so an unsigned compare orders it
        function logic [45:0] rank_of(in_item_t it);
            return {it.priority_level ^ 8'h80, it.year_value, it.month_value, it.day_value,
                    it.hour_value, it.minute_value, it.second_value};
        endfunction

        function out_item_t predict_result(in_item_t it);
            out_item_t   res;
            logic [45:0] rank;
            int          pos;
            res = '0;
            res.status = ST_OK;
            if (it.opcode == OP_INSERT) begin
                if (fill >= QDEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // new entry goes behind every entry with a greater or equal key
                    rank = rank_of(it);
                    pos  = 0;
                    while (pos < fill && slots[pos].rank >= rank)
                        pos++;
                    for (int i = fill; i > pos; i--)
                        slots[i] = slots[i - 1];
                    slots[pos].rank = rank;
                    slots[pos].tag  = it.payload_tag;
                    fill++;
                end
            end else if (fill == 0) begin
                res.status = ST_EMPTY;
            end else begin
                // head leaves, the rest moves up
                res.out_priority = slots[0].rank[45:38] ^ 8'h80;
                res.out_year     = slots[0].rank[37:26];
                res.out_month    = slots[0].rank[25:22];
                res.out_day      = slots[0].rank[21:17];
                res.out_hour     = slots[0].rank[16:12];
                res.out_minute   = slots[0].rank[11:6];
                res.out_second   = slots[0].rank[5:0];
                res.out_tag      = slots[0].tag;
                for (int i = 1; i < fill; i++)
                    slots[i - 1] = slots[i];
                fill--;
            end
            res.occupancy = OCC_W'(fill);
            return res;
        endfunction

        function void note_accepted(in_item_t it);
            pending_results.push_back(predict_result(it));
        endfunction

        function string describe(out_item_t r);
            return $sformatf("st=%0d pri=%0d date=%0d-%0d-%0d time=%0d:%0d:%0d tag=%h occ=%0d",
                             r.status, r.out_priority, r.out_year, r.out_month, r.out_day,
                             r.out_hour, r.out_minute, r.out_second, r.out_tag, r.occupancy);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            string     bad;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: %s", describe(got));
                return;
            end
            exp = pending_results.pop_front();
            bad = "";
            if (got.status !== exp.status)             bad = {bad, " status"};
            if (got.out_priority !== exp.out_priority) bad = {bad, " out_priority"};
            if (got.out_year !== exp.out_year)         bad = {bad, " out_year"};
            if (got.out_month !== exp.out_month)       bad = {bad, " out_month"};
            if (got.out_day !== exp.out_day)           bad = {bad, " out_day"};
            if (got.out_hour !== exp.out_hour)         bad = {bad, " out_hour"};
            if (got.out_minute !== exp.out_minute)     bad = {bad, " out_minute"};
            if (got.out_second !== exp.out_second)     bad = {bad, " out_second"};
            if (got.out_tag !== exp.out_tag)           bad = {bad, " out_tag"};
            if (got.occupancy !== exp.occupancy)       bad = {bad, " occupancy"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch in%s", bad);
                    $display("  expected %s", describe(exp));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int        tx_idle_pct  = 29;
    int        rx_idle_pct  = 29;
    bit        hold_request = 1'b0;
    int        hold_len     = 0;
    int        cycle_count  = 0;
    in_item_t  recent_item  = '0;

    priority_order_checker board = new();

    sorted_priority_queue_multikey_top #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_left    = hold_len;
                hold_request = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_data);
    end

    function automatic in_item_t entry_item(logic [7:0] pri, logic [11:0] yr, logic [3:0] mo,
                                            logic [4:0] dy, logic [4:0] hr, logic [5:0] mi,
                                            logic [5:0] sc, logic [15:0] tag);
        in_item_t it;
        it.opcode         = OP_INSERT;
        it.priority_level = pri;
        it.year_value     = yr;
        it.month_value    = mo;
        it.day_value      = dy;
        it.hour_value     = hr;
        it.minute_value   = mi;
        it.second_value   = sc;
        it.payload_tag    = tag;
        return it;
    endfunction

    // random item; keys often come from a narrow set or repeat a recent key
    function automatic in_item_t random_item(int insert_pct);
        in_item_t it;
        bit [6:0] narrow;
        narrow = 7'($urandom);
        if ($urandom_range(99) < 20) begin
            it = recent_item;
        end else begin
            it.priority_level = narrow[0] ? 8'($urandom_range(2)) - 8'd1 : 8'($urandom);
            it.year_value     = narrow[1] ? 12'd2024 + 12'($urandom_range(1)) : 12'($urandom);
            it.month_value    = narrow[2] ? 4'd1 + 4'($urandom_range(1)) : 4'($urandom);
            it.day_value      = narrow[3] ? 5'd1 + 5'($urandom_range(1)) : 5'($urandom);
            it.hour_value     = narrow[4] ? 5'($urandom_range(1)) : 5'($urandom);
            it.minute_value   = narrow[5] ? 6'($urandom_range(1)) : 6'($urandom);
            it.second_value   = narrow[6] ? 6'($urandom_range(1)) : 6'($urandom);
        end
        it.payload_tag = 16'($urandom);
        it.opcode      = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        if (it.opcode == OP_INSERT)
            recent_item = it;
        return it;
    endfunction

    // offer one item after random idle cycles, hold it until accepted
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        board.note_accepted(it);
    endtask

    // stop offering and wait for every expected result
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.outstanding() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(input int count, input int insert_pct);
        for (int n = 0; n < count; n++)
            send_item(random_item(insert_pct));
        drain();
    endtask

    // reset, stimulus, end of run
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty remove, key extremes, sign order, equal keys
        send_item(random_item(0));
        send_item(entry_item(8'h7F, 12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F, 16'hFFFF));
        send_item(entry_item(8'h80, 12'h000, 4'h0, 5'h00, 5'h00, 6'h00, 6'h00, 16'h0000));
        send_item(entry_item(8'h00, 12'd2024, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30, 16'h0001));
        send_item(entry_item(8'h00, 12'd2024, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30, 16'h0002));
        send_item(entry_item(8'h00, 12'd2024, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30, 16'h0003));
        send_item(entry_item(8'h00, 12'd2024, 4'd6, 5'd15, 5'd12, 6'd30, 6'd31, 16'h0004));
        send_item(entry_item(8'hFF, 12'd2024, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30, 16'h0005));
        send_item(entry_item(8'h01, 12'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 16'h0006));
        for (int n = 0; n < 9; n++)
            send_item(random_item(0));
        drain();

        // mixed traffic, then fill past full, then empty past empty
        run_phase(150, 50);
        run_phase(120, 85);
        run_phase(120, 15);

        // stretch with no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(150, 55);
        tx_idle_pct = 29;
        rx_idle_pct = 29;

        // long receiver hold-off while the sender keeps offering
        hold_len     = 150;
        hold_request = 1'b1;
        run_phase(100, 70);

        run_phase(200, 50);

        repeat (4) @(posedge aclk);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
